/* rtl/gpr_pkg.sv */
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types, constants and helpers for the glyph pixel replicator.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int FONT_WIDTH = 8;
  localparam int MAX_SCALE  = 8;

  localparam int SCALE_W  = 4;
  localparam int BITS_W   = 8;
  localparam int CIDX_W   = 3;
  localparam int POS_W    = 8;
  localparam int EXP_W    = BITS_W * MAX_SCALE;
  localparam int CNT_W    = $clog2(MAX_SCALE);
  localparam int Q_DEPTH  = 2;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2);

  typedef struct packed {
    logic [BITS_W-1:0] glyph_bits;
    logic [CIDX_W-1:0] glyph_column_index;
    logic [POS_W-1:0]  char_column;
    logic [POS_W-1:0]  char_page;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  out_column;
    logic [POS_W-1:0]  out_page;
    logic [BITS_W-1:0] pixel_byte;
    logic              last;
  } out_rsp_t;

  // One classified request handed from front to back.
  typedef struct packed {
    logic [EXP_W-1:0]   exp;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   page;
    logic [SCALE_W-1:0] k;
    logic [SCALE_W-1:0] h;
  } cmd_t;

  // Repeat each source bit k times; lowest bits go to the lowest page.
  function automatic logic [EXP_W-1:0] expand_column(
    input logic [BITS_W-1:0]  bits,
    input logic [SCALE_W-1:0] k
  );
    logic [EXP_W-1:0] e;
    e = '0;
    for (int kk = 2; kk <= MAX_SCALE; kk++) begin
      if (k == SCALE_W'(kk)) begin
        for (int b = 0; b < BITS_W; b++) begin
          for (int r = 0; r < kk; r++) begin
            e[b * kk + r] = bits[b];
          end
        end
      end
    end
    return e;
  endfunction

endpackage

/* rtl/gpr_queue.sv */
// ----------------------------------------------------------------------------
// gpr_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module gpr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gpr_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gpr_pkg::cmd_t pop_data
);
  import gpr_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/gpr_front.sv */
// ----------------------------------------------------------------------------
// gpr_front
// Holds the scale register, accepts requests, drops out-of-font columns and
// builds the expanded column and base position for the back part.
// ----------------------------------------------------------------------------
module gpr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gpr_pkg::SCALE_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gpr_pkg::in_req_t              in_data,
  output logic                          push_valid,
  input  logic                          push_ready,
  output gpr_pkg::cmd_t                 push_data
);
  import gpr_pkg::*;

  logic [SCALE_W-1:0]    scale_r, scale_nxt;
  logic [SCALE_W-1:0]    eff_s, k, h;
  logic [CIDX_W+SCALE_W-1:0] col_off;
  logic                  idx_ok;

  always_comb begin
    scale_nxt = cfg_we ? cfg_wdata : scale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  // Zero acts as one; saturate above the largest scale.
  always_comb begin
    eff_s = scale_r;
    if (eff_s == '0) begin
      eff_s = SCALE_W'(1);
    end
    if (eff_s > SCALE_W'(MAX_SCALE)) begin
      eff_s = SCALE_W'(MAX_SCALE);
    end
    k = (eff_s == SCALE_W'(1)) ? SCALE_W'(2) : eff_s;
    h = (eff_s == SCALE_W'(1)) ? SCALE_W'(1) : eff_s;
  end

  assign idx_ok  = (32'(in_data.glyph_column_index) < FONT_WIDTH);
  assign col_off = (CIDX_W+SCALE_W)'(in_data.glyph_column_index) *
                   (CIDX_W+SCALE_W)'(h);

  assign in_ready   = push_ready;
  assign push_valid = in_valid && idx_ok;

  always_comb begin
    push_data.exp  = expand_column(in_data.glyph_bits, k);
    push_data.col  = in_data.char_column + POS_W'(col_off);
    push_data.page = in_data.char_page;
    push_data.k    = k;
    push_data.h    = h;
  end

endmodule

/* rtl/gpr_back.sv */
// ----------------------------------------------------------------------------
// gpr_back
// Walks columns and pages of one queued request and emits one result byte
// per cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module gpr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  gpr_pkg::cmd_t     pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gpr_pkg::out_rsp_t out_data
);
  import gpr_pkg::*;

  cmd_t             cmd_r, cmd_nxt;
  logic             active_r, active_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0] r_r, r_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_r, out_nxt;
  logic             issue, p_end, is_last;

  assign issue   = active_r && (!out_valid_r || out_ready);
  assign p_end   = (SCALE_W'(p_r) == cmd_r.k - 1'b1);
  assign is_last = p_end && (SCALE_W'(r_r) == cmd_r.h - 1'b1);

  // Take the next request when idle or once the current one issues its final byte.
  assign pop_ready = !active_r || (issue && is_last);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    cmd_nxt       = cmd_r;
    active_nxt    = active_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (issue) begin
      out_valid_nxt      = 1'b1;
      out_nxt.out_column = col_r;
      out_nxt.out_page   = cmd_r.page + POS_W'(p_r);
      out_nxt.pixel_byte = cmd_r.exp[BITS_W * p_r +: BITS_W];
      out_nxt.last       = is_last;
      if (is_last) begin
        active_nxt = 1'b0;
      end else if (p_end) begin
        p_nxt   = '0;
        r_nxt   = r_r + 1'b1;
        col_nxt = col_r + 1'b1;
      end else begin
        p_nxt = p_r + 1'b1;
      end
    end

    if (pop_valid && pop_ready) begin
      cmd_nxt    = pop_data;
      active_nxt = 1'b1;
      p_nxt      = '0;
      r_nxt      = '0;
      col_nxt    = pop_data.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    p_r   <= p_nxt;
    r_r   <= r_nxt;
    col_r <= col_nxt;
    out_r <= out_nxt;
  end

endmodule

/* rtl/glyph_pixel_replicator.sv */
// ----------------------------------------------------------------------------
// glyph_pixel_replicator
// Scales one glyph column by pixel replication into page bytes.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_ready  gpr_pkg::in_req_t
//   out_     out        out_valid/out_ready gpr_pkg::out_rsp_t
//   cfg_     in         cfg_we             scale, 4 bits
//
// A request yields h*k bytes (4 at scale 2, 64 at scale 8), one per cycle
// while out_ready allows, set by the back part's single output register.
// Data passes queue write, back load and output register. Requests for
// columns beyond the font are taken and dropped. The queue lets the front
// accept while the back stalls on out_ready. Reset (rst_n, synchronous) sets scale to 2.
// ----------------------------------------------------------------------------
module glyph_pixel_replicator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gpr_pkg::SCALE_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gpr_pkg::in_req_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gpr_pkg::out_rsp_t           out_data
);
  import gpr_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  gpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
